// File: rtl/mtwg_pkg.sv
// Shared types, constants and the output tempering function of the MT19937 word generator.
`default_nettype none

package mtwg_pkg;

  localparam int unsigned STATE_WORDS_DEF  = 624;
  localparam int unsigned SHIFT_OFFSET_DEF = 397;
  localparam int unsigned WORD_W           = 32;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_GEN  = 1'b1;

  typedef struct packed {
    logic              gen;
    logic [WORD_W-1:0] seed;
  } cmd_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mtwg_fifo.sv
// Two-entry queue used for the request front end and the result side.
`default_nettype none

module mtwg_fifo import mtwg_pkg::*; #(
  parameter int unsigned WIDTH = WORD_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] data_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtwg_core.sv
// Back end: state memory, seed fill, block twist and word readout sequencer.
`default_nettype none

module mtwg_core import mtwg_pkg::*; #(
  parameter int unsigned STATE_WORDS  = STATE_WORDS_DEF,
  parameter int unsigned SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  output logic                   res_push,
  output logic      [WORD_W-1:0] res_word,
  input  wire logic              res_full
);

  localparam int unsigned AW = $clog2(STATE_WORDS);
  localparam int unsigned IW = $clog2(STATE_WORDS + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(STATE_WORDS - 1);
  localparam logic [IW-1:0] END_IDX  = IW'(STATE_WORDS);
  localparam logic [SW-1:0] WRAP     = SW'(STATE_WORDS);
  localparam logic [AW-1:0] ADDR_ONE = AW'(1 % STATE_WORDS);
  localparam logic [AW-1:0] ADDR_FAR = AW'(SHIFT_OFFSET % STATE_WORDS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SEED_MUL = 8'b0000_0010,
    S_SEED_ADD = 8'b0000_0100,
    S_TW_START = 8'b0000_1000,
    S_TW_PRIME = 8'b0001_0000,
    S_TW_RUN   = 8'b0010_0000,
    S_GEN_RD   = 8'b0100_0000,
    S_GEN_OUT  = 8'b1000_0000
  } state_t;

  logic [WORD_W-1:0] mem [STATE_WORDS];

  state_t            state_r,    state_nxt;
  logic [WORD_W-1:0] prev_r,     prev_nxt;
  logic [WORD_W-1:0] prod_r,     prod_nxt;
  logic [IW-1:0]     cnt_r,      cnt_nxt;
  logic [IW-1:0]     rd_idx_r,   rd_idx_nxt;
  logic              seeded_r,   seeded_nxt;
  logic              pend_gen_r, pend_gen_nxt;
  logic              upper_r,    upper_nxt;
  logic [WORD_W-1:0] rda_r;
  logic [WORD_W-1:0] rdb_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re_a;
  logic              re_b;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  logic              can_start;
  logic [WORD_W-1:0] seed_sel;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] twist_word;
  logic [SW-1:0]     near_sum;
  logic [SW-1:0]     far_sum;
  logic [SW-1:0]     near_mod;
  logic [SW-1:0]     far_mod;

  assign res_word   = temper(rda_r);
  assign can_start  = cmd_valid &&
                      ((state_r == S_IDLE) || ((state_r == S_GEN_OUT) && !res_full));
  assign cmd_pop    = can_start;
  assign seed_sel   = (cmd.gen == REQ_GEN) ? DEFAULT_SEED : cmd.seed;
  assign seed_word  = prod_r + {{(WORD_W-IW){1'b0}}, cnt_r};
  assign mix        = {upper_r, rda_r[WORD_W-2:0]};
  assign twist_word = rdb_r ^ (mix >> 1) ^ (rda_r[0] ? TWIST_MATRIX : '0);
  assign near_sum   = {1'b0, cnt_r} + SW'(2);
  assign far_sum    = {1'b0, cnt_r} + SW'(1 + SHIFT_OFFSET);
  assign near_mod   = (near_sum >= WRAP) ? near_sum - WRAP : near_sum;
  assign far_mod    = (far_sum >= WRAP) ? far_sum - WRAP : far_sum;

  always_comb begin
    state_nxt    = state_r;
    prev_nxt     = prev_r;
    prod_nxt     = prod_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    seeded_nxt   = seeded_r;
    pend_gen_nxt = pend_gen_r;
    upper_nxt    = upper_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = seed_word;
    re_a         = 1'b0;
    re_b         = 1'b0;
    addr_a       = '0;
    addr_b       = '0;
    res_push     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_SEED_MUL: begin
        prod_nxt  = SEED_MULT * (prev_r ^ (prev_r >> 30));
        state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        we       = 1'b1;
        waddr    = cnt_r[AW-1:0];
        wdata    = seed_word;
        prev_nxt = seed_word;
        if (cnt_r == LAST_IDX) begin
          pend_gen_nxt = 1'b0;
          state_nxt    = pend_gen_r ? S_TW_START : S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_SEED_MUL;
        end
      end
      S_TW_START: begin
        re_a      = 1'b1;
        addr_a    = '0;
        state_nxt = S_TW_PRIME;
      end
      S_TW_PRIME: begin
        upper_nxt = rda_r[WORD_W-1];
        re_a      = 1'b1;
        re_b      = 1'b1;
        addr_a    = ADDR_ONE;
        addr_b    = ADDR_FAR;
        cnt_nxt   = '0;
        state_nxt = S_TW_RUN;
      end
      S_TW_RUN: begin
        we        = 1'b1;
        waddr     = cnt_r[AW-1:0];
        wdata     = twist_word;
        upper_nxt = rda_r[WORD_W-1];
        if (cnt_r == LAST_IDX) begin
          rd_idx_nxt = '0;
          state_nxt  = S_GEN_RD;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
          re_a    = 1'b1;
          re_b    = 1'b1;
          addr_a  = near_mod[AW-1:0];
          addr_b  = far_mod[AW-1:0];
        end
      end
      S_GEN_RD: begin
        re_a       = 1'b1;
        addr_a     = rd_idx_r[AW-1:0];
        rd_idx_nxt = rd_idx_r + IW'(1);
        state_nxt  = S_GEN_OUT;
      end
      S_GEN_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (can_start) begin
      if ((cmd.gen == REQ_SEED) || !seeded_r) begin
        we           = 1'b1;
        waddr        = '0;
        wdata        = seed_sel;
        prev_nxt     = seed_sel;
        cnt_nxt      = IW'(1);
        seeded_nxt   = 1'b1;
        rd_idx_nxt   = END_IDX;
        pend_gen_nxt = (cmd.gen == REQ_GEN);
        state_nxt    = S_SEED_MUL;
      end else if (rd_idx_r >= END_IDX) begin
        state_nxt = S_TW_START;
      end else begin
        state_nxt = S_GEN_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rda_r <= mem[addr_a];
    end
    if (re_b) begin
      rdb_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    prod_r  <= prod_nxt;
    cnt_r   <= cnt_nxt;
    upper_r <= upper_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_idx_r   <= END_IDX;
      seeded_r   <= 1'b0;
      pend_gen_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      seeded_r   <= seeded_nxt;
      pend_gen_r <= pend_gen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mt19937_word_generator.sv
// Generate request, state block ready: state word registered, then tempered into the result queue.
// Generate request on a used-up block: twist first (one state word per cycle), then readout.
// Seed request: seed word written on accept, then a multiply and an add per word;
// a generate before any seed runs that fill with the default seed first.
// Reset (rst_n low, synchronous): queues empty, generator unseeded, state block marked used up.
`default_nettype none

module mt19937_word_generator import mtwg_pkg::*; #(
  parameter int unsigned STATE_WORDS  = STATE_WORDS_DEF,
  parameter int unsigned SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              in_req_type,
  input  wire logic [WORD_W-1:0] in_seed_value,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic      [WORD_W-1:0] out_random_word
);

  cmd_t              in_cmd;
  cmd_t              q_cmd;
  logic              q_empty;
  logic              q_pop;
  logic              res_push;
  logic              res_full;
  logic [WORD_W-1:0] res_word;

  assign in_cmd.gen  = (in_req_type == REQ_GEN);
  assign in_cmd.seed = in_seed_value;

  mtwg_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (in_cmd),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_cmd)
  );

  mtwg_core #(
    .STATE_WORDS  (STATE_WORDS),
    .SHIFT_OFFSET (SHIFT_OFFSET)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  mtwg_fifo #(
    .WIDTH (WORD_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_word),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_random_word)
  );

endmodule

`default_nettype wire

// File: test/mt19937_word_generator_tb.sv
// Testbench for the MT19937 word generator: seed and generate transactions vs. a local predictor.
module mt19937_word_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtwg_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 1300;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_push       = 1'b0;
  logic              in_req_type   = REQ_GEN;
  logic [WORD_W-1:0] in_seed_value = '0;
  logic              out_pop       = 1'b0;
  logic              in_full;
  logic              out_empty;
  logic [WORD_W-1:0] out_random_word;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  logic [WORD_W-1:0] mt_pool [STATE_WORDS_DEF];
  int unsigned       draw_pos = STATE_WORDS_DEF;
  bit                pool_seeded = 1'b0;
  logic [WORD_W-1:0] expected_words [$];

  mt19937_word_generator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_seed_value  (in_seed_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_random_word(out_random_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void seed_pool(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] p;
    mt_pool[0] = seed;
    for (int j = 1; j < STATE_WORDS_DEF; j++) begin
      p = mt_pool[j-1];
      mt_pool[j] = SEED_MULT * (p ^ (p >> 30)) + WORD_W'(j);
    end
    draw_pos = STATE_WORDS_DEF;
    pool_seeded = 1'b1;
  endfunction

  function automatic void twist_pool();
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] v;
    for (int i = 0; i < STATE_WORDS_DEF; i++) begin
      nxt = mt_pool[(i + 1) % STATE_WORDS_DEF];
      mix = {mt_pool[i][WORD_W-1], nxt[WORD_W-2:0]};
      v = mt_pool[(i + SHIFT_OFFSET_DEF) % STATE_WORDS_DEF] ^ (mix >> 1);
      if (nxt[0]) begin
        v = v ^ TWIST_MATRIX;
      end
      mt_pool[i] = v;
    end
    draw_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic void apply_request(input logic req, input logic [WORD_W-1:0] seed);
    if (req == REQ_SEED) begin
      seed_pool(seed);
    end else begin
      if (!pool_seeded) begin
        seed_pool(DEFAULT_SEED);
      end
      if (draw_pos >= STATE_WORDS_DEF) begin
        twist_pool();
      end
      expected_words.push_back(temper_word(mt_pool[draw_pos]));
      draw_pos++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  task automatic send_request(input logic req, input logic [WORD_W-1:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_req_type   <= req;
    in_seed_value <= seed;
    do @(posedge clk); while (in_full !== 1'b0);
    apply_request(req, seed);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // generate before any seed falls back to the default seed
  task automatic test_default_seed();
    repeat (3) send_request(REQ_GEN, $urandom());
    wait_drained();
  endtask

  task automatic test_seed_extremes();
    send_request(REQ_SEED, '0);
    repeat (2) send_request(REQ_GEN, $urandom());
    send_request(REQ_SEED, '1);
    repeat (2) send_request(REQ_GEN, '0);
    send_request(REQ_SEED, DEFAULT_SEED);
    send_request(REQ_GEN, '1);
  endtask

  // back-to-back seeds, reseed mid-block and restart of a sequence
  task automatic test_reseed();
    logic [WORD_W-1:0] first_seed;
    first_seed = $urandom();
    send_request(REQ_SEED, first_seed);
    send_request(REQ_SEED, $urandom());
    repeat (2) send_request(REQ_GEN, $urandom());
    send_request(REQ_SEED, first_seed);
    send_request(REQ_GEN, $urandom());
    send_request(REQ_SEED, first_seed);
    send_request(REQ_GEN, $urandom());
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned count);
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) begin
        send_request(REQ_SEED, $urandom());
      end else begin
        send_request(REQ_GEN, $urandom());
      end
    end
  endtask

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_words
    logic [WORD_W-1:0] want;
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_random_word));
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want) begin
            report_mismatch($sformatf("random_word %h, expected %h", out_random_word, want));
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 82;
    test_default_seed();
    test_seed_extremes();
    test_reseed();
    test_random(33, 82, 130);
    test_random(82, 33, 130);
    test_random(0, 0, 130);
    wait_drained();
    in_push <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
